// ===== hw/rtl/pcmt_pkg.sv =====
// shared constants, codes and beat types of the priority collection max table
package pcmt_pkg;

    localparam int ENTRIES        = 64;
    localparam int DATA_WIDTH     = 32;
    localparam int PRIORITY_WIDTH = 16;
    localparam int ID_W           = $clog2(ENTRIES);
    localparam int CNT_W          = ID_W + 1;
    localparam int MEM_W          = DATA_WIDTH + PRIORITY_WIDTH;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_PROMOTE = 3'd1;
    localparam logic [2:0] OP_PEEK    = 3'd2;
    localparam logic [2:0] OP_POP     = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BADID = 2'd3;

    typedef struct packed {
        logic [2:0]            operation;
        logic [ID_W-1:0]       entry_id;
        logic [DATA_WIDTH-1:0] payload;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [ID_W-1:0]           result_id;
        logic [DATA_WIDTH-1:0]     result_data;
        logic [PRIORITY_WIDTH-1:0] result_priority;
        logic                      is_live;
    } out_item_t;

    typedef struct packed {
        logic            clear;
        logic            sample;
        logic            live;
        logic [ID_W-1:0] id;
    } scan_ctl_t;

endpackage

// ===== hw/rtl/pcmt_ram.sv =====
// generic single write port, single registered read port memory
module pcmt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/pcmt_scan.sv =====
// running max tracker: one priority comparator fed one table entry per cycle
module pcmt_scan
    import pcmt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  scan_ctl_t                 ctl,
    input  logic [PRIORITY_WIDTH-1:0] prio,
    input  logic [DATA_WIDTH-1:0]     data,
    output logic                      found,
    output logic [ID_W-1:0]           best_id,
    output logic [PRIORITY_WIDTH-1:0] best_prio,
    output logic [DATA_WIDTH-1:0]     best_data
);

    logic                      found_reg;
    logic                      found_next;
    logic [ID_W-1:0]           best_id_reg;
    logic [PRIORITY_WIDTH-1:0] best_prio_reg;
    logic [DATA_WIDTH-1:0]     best_data_reg;
    logic                      take;

    // ties go to the later (larger) id
    assign take = ctl.sample && ctl.live && (!found_reg || prio >= best_prio_reg);

    always_comb
    begin
        found_next = found_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.clear && take)
        begin
            best_id_reg   <= ctl.id;
            best_prio_reg <= prio;
            best_data_reg <= data;
        end
    end

    assign found     = found_reg;
    assign best_id   = best_id_reg;
    assign best_prio = best_prio_reg;
    assign best_data = best_data_reg;

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> !found_reg)
        else $error("scan: clear did not drop found");

    a_first_live_taken: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.sample && ctl.live && !ctl.clear && !found_reg
            |=> found_reg && best_id_reg == $past(ctl.id))
        else $error("scan: first live entry not captured");

    a_dead_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.sample && !ctl.live && !ctl.clear |=> $stable(found_reg))
        else $error("scan: retired entry changed found");

endmodule

// ===== hw/rtl/priority_collection_max_table.sv =====
// top level: sequencer, live marks, id counter and result register
// An add is handled without a table read, promote and query first read their entry, and
// peek-max and pop-max search every id handed out so far (or answer empty while no id
// has been handed out): the max search reads the table memory through its single read
// port one entry per cycle into one priority comparator. A new beat is taken only when
// the sequencer is idle; a finished result waits in the output register while the next
// beat is accepted. There are no configuration registers and no clearing pass after reset.
module priority_collection_max_table_core
    import pcmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_PICK  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);
    localparam logic [PRIORITY_WIDTH-1:0] PRIO_TOP = '1;

    logic [2:0]                state_reg, state_next;
    logic [CNT_W-1:0]          next_free_reg, next_free_next;
    logic [ENTRIES-1:0]        live_reg, live_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_item_reg;
    out_item_t                 res_reg, res_next;
    in_item_t                  cmd_reg;
    logic [ID_W-1:0]           scan_idx_reg, scan_idx_next;
    logic                      samp_valid_reg;
    logic [ID_W-1:0]           samp_idx_reg;

    logic                      accept;
    logic                      known;
    logic                      mem_wr_en;
    logic [ID_W-1:0]           mem_wr_addr;
    logic [MEM_W-1:0]          mem_wr_data;
    logic                      mem_rd_en;
    logic [ID_W-1:0]           mem_rd_addr;
    logic [MEM_W-1:0]          mem_rd_data;
    logic [DATA_WIDTH-1:0]     rd_data_word;
    logic [PRIORITY_WIDTH-1:0] rd_prio;
    logic [PRIORITY_WIDTH-1:0] promoted_prio;
    scan_ctl_t                 scan_ctl;
    logic                      scan_found;
    logic [ID_W-1:0]           scan_best_id;
    logic [PRIORITY_WIDTH-1:0] scan_best_prio;
    logic [DATA_WIDTH-1:0]     scan_best_data;

    pcmt_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (MEM_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    pcmt_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .prio      (rd_prio),
        .data      (rd_data_word),
        .found     (scan_found),
        .best_id   (scan_best_id),
        .best_prio (scan_best_prio),
        .best_data (scan_best_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign rd_data_word  = mem_rd_data[MEM_W-1 -: DATA_WIDTH];
    assign rd_prio       = mem_rd_data[PRIORITY_WIDTH-1:0];
    assign promoted_prio = (rd_prio == PRIO_TOP) ? rd_prio : rd_prio + 1'b1;
    assign known         = {1'b0, cmd_reg.entry_id} < next_free_reg;

    always_comb
    begin
        scan_ctl.clear  = (state_reg == S_EXEC);
        scan_ctl.sample = samp_valid_reg;
        scan_ctl.live   = live_reg[samp_idx_reg];
        scan_ctl.id     = samp_idx_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        next_free_next = next_free_reg;
        live_next      = live_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        scan_idx_next  = scan_idx_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = cmd_reg.entry_id;
        mem_wr_data    = {rd_data_word, promoted_prio};
        mem_rd_en      = 1'b0;
        mem_rd_addr    = cmd_reg.entry_id;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next   = '0;
                state_next = S_DONE;
                case (cmd_reg.operation) inside
                    OP_ADD:
                    begin
                        if (next_free_reg == FULL_COUNT)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = next_free_reg[ID_W-1:0];
                            mem_wr_data = {cmd_reg.payload, PRIORITY_WIDTH'(0)};
                            live_next[next_free_reg[ID_W-1:0]] = 1'b1;
                            next_free_next = next_free_reg + 1'b1;
                            res_next.status      = ST_OK;
                            res_next.result_id   = next_free_reg[ID_W-1:0];
                            res_next.result_data = cmd_reg.payload;
                            res_next.is_live     = 1'b1;
                        end
                    end
                    OP_PROMOTE:
                    begin
                        if (!known || !live_reg[cmd_reg.entry_id])
                        begin
                            res_next.status = ST_BADID;
                        end
                        else
                        begin
                            mem_rd_en  = 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (!known)
                        begin
                            res_next.status = ST_BADID;
                        end
                        else
                        begin
                            mem_rd_en  = 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                    OP_PEEK, OP_POP:
                    begin
                        scan_idx_next = '0;
                        if (next_free_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        res_next.status = ST_OK;
                    end
                endcase
            end
            S_WAIT:
            begin
                res_next.status      = ST_OK;
                res_next.result_id   = cmd_reg.entry_id;
                res_next.result_data = rd_data_word;
                if (cmd_reg.operation == OP_PROMOTE)
                begin
                    mem_wr_en                = 1'b1;
                    res_next.result_priority = promoted_prio;
                    res_next.is_live         = 1'b1;
                end
                else
                begin
                    res_next.is_live         = live_reg[cmd_reg.entry_id];
                    res_next.result_priority = live_reg[cmd_reg.entry_id] ?
                                               rd_prio : PRIORITY_WIDTH'(0);
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                mem_rd_en     = 1'b1;
                mem_rd_addr   = scan_idx_reg;
                scan_idx_next = scan_idx_reg + 1'b1;
                if ({1'b0, scan_idx_reg} == next_free_reg - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last sample goes through the comparator this cycle
                state_next = S_PICK;
            end
            S_PICK:
            begin
                res_next = '0;
                if (!scan_found)
                begin
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    res_next.status          = ST_OK;
                    res_next.result_id       = scan_best_id;
                    res_next.result_data     = scan_best_data;
                    res_next.result_priority = scan_best_prio;
                    res_next.is_live         = (cmd_reg.operation == OP_PEEK);
                    if (cmd_reg.operation == OP_POP)
                    begin
                        live_next[scan_best_id] = 1'b0;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            next_free_reg  <= '0;
            live_reg       <= '0;
            out_valid_reg  <= 1'b0;
            samp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_free_reg  <= next_free_next;
            live_reg       <= live_next;
            out_valid_reg  <= out_valid_next;
            samp_valid_reg <= (state_reg == S_SCAN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= in_item;
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            out_item_reg <= res_reg;
        end
        res_reg      <= res_next;
        scan_idx_reg <= scan_idx_next;
        samp_idx_reg <= scan_idx_reg;
    end

endmodule
